FILE: hw/rtl/ucal_pkg.sv
package ucal_pkg;

	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned BASE_YEAR    = 1970;

	// Quotient bits of seconds / 86400: the largest day count is 49710
	localparam int unsigned QB = 16;

	// 86400 = 2^7 * 675: days = ((secs >> 7) * ceil(2^35 / 675)) >> 35,
	// exact for every 25-bit value of secs >> 7
	localparam int unsigned SECS_W      = 25;
	localparam int unsigned RECIP_SHIFT = 35;
	localparam int unsigned PROD_W      = 51;
	localparam logic [25:0] DAY_RECIP   = 26'd50903317;

	localparam int unsigned YEAR_W = 12;
	localparam logic [YEAR_W-1:0] YEAR_INIT = YEAR_W'(BASE_YEAR);
	localparam logic [6:0] YC_INIT = 7'(BASE_YEAR % 100);
	localparam logic [1:0] CC_INIT = 2'((BASE_YEAR / 100) % 4);
	localparam logic [6:0] YC_LAST = 7'd99;

	localparam logic [3:0] LAST_MONTH = 4'd11;
	localparam logic [3:0] FEB        = 4'd1;
	localparam logic [8:0] DAYS_LEAP  = 9'd366;
	localparam logic [8:0] DAYS_NORM  = 9'd365;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Microcode
	localparam int unsigned PC_W = 3;
	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_DIV,
		OP_YEAR,
		OP_MON,
		OP_OUT
	} ctl_op_t;

	localparam pc_t STEP_WAIT = 3'd0;
	localparam pc_t STEP_DIV  = 3'd1;
	localparam pc_t STEP_YEAR = 3'd2;
	localparam pc_t STEP_MON  = 3'd3;
	localparam pc_t STEP_OUT  = 3'd4;

	typedef struct packed {
		ctl_op_t op;
		pc_t     nxt;	// taken when the step's condition holds, else the step repeats
	} ucode_t;

	typedef struct packed {
		ctl_op_t op;
	} ctl_t;

	typedef struct packed {
		logic in_fire;
		logic year_done;
		logic mon_done;
		logic out_free;
	} flags_t;

	function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
		logic [4:0] len;
		len = (idx > LAST_MONTH) ? MONTH_LEN[LAST_MONTH] : MONTH_LEN[idx];
		if (idx == FEB && leap) begin
			len = len + 5'd1;
		end
		return len;
	endfunction

endpackage

FILE: hw/rtl/ucal_rom.sv
module ucal_rom (
	input  ucal_pkg::pc_t    addr,
	output ucal_pkg::ucode_t word
);

	always_comb begin
		case (addr)
			ucal_pkg::STEP_WAIT: word = '{op: ucal_pkg::OP_WAIT, nxt: ucal_pkg::STEP_DIV};
			ucal_pkg::STEP_DIV:  word = '{op: ucal_pkg::OP_DIV,  nxt: ucal_pkg::STEP_YEAR};
			ucal_pkg::STEP_YEAR: word = '{op: ucal_pkg::OP_YEAR, nxt: ucal_pkg::STEP_MON};
			ucal_pkg::STEP_MON:  word = '{op: ucal_pkg::OP_MON,  nxt: ucal_pkg::STEP_OUT};
			ucal_pkg::STEP_OUT:  word = '{op: ucal_pkg::OP_OUT,  nxt: ucal_pkg::STEP_WAIT};
			default:             word = '{op: ucal_pkg::OP_WAIT, nxt: ucal_pkg::STEP_WAIT};
		endcase
	end

endmodule

FILE: hw/rtl/ucal_datapath.sv
module ucal_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ucal_pkg::ctl_t      ctl,
	output ucal_pkg::flags_t    flags,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         epoch_seconds,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [11:0]         cal_year,
	output logic [3:0]          cal_month,
	output logic [4:0]          cal_day
);

	logic [ucal_pkg::SECS_W-1:0]     secs_q;	// seconds / 128
	logic [ucal_pkg::QB-1:0]         days_q;
	logic [ucal_pkg::YEAR_W-1:0]     year_q;
	logic [6:0]                      yc_q;	// year within century
	logic [1:0]                      cc_q;	// century mod 4
	logic [3:0]                      mon_q;
	logic                            out_valid_q;
	logic [11:0]                     year_out_q;
	logic [3:0]                      month_out_q;
	logic [4:0]                      day_out_q;

	logic                            leap;
	logic [8:0]                      ylen;
	logic [4:0]                      mlen;
	logic [ucal_pkg::PROD_W-1:0]     day_prod;

	assign leap     = (year_q[1:0] == 2'b00) && ((yc_q != 7'd0) || (cc_q == 2'd0));
	assign ylen     = leap ? ucal_pkg::DAYS_LEAP : ucal_pkg::DAYS_NORM;
	assign mlen     = ucal_pkg::month_len(mon_q, leap);
	assign day_prod = ucal_pkg::PROD_W'(secs_q) * ucal_pkg::PROD_W'(ucal_pkg::DAY_RECIP);

	assign in_stall = (ctl.op != ucal_pkg::OP_WAIT);

	always_comb begin
		flags.in_fire   = (ctl.op == ucal_pkg::OP_WAIT) && in_valid;
		flags.year_done = days_q < {{(ucal_pkg::QB-9){1'b0}}, ylen};
		flags.mon_done  = (days_q < {{(ucal_pkg::QB-5){1'b0}}, mlen})
			|| (mon_q == ucal_pkg::LAST_MONTH);
		flags.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			ucal_pkg::OP_WAIT: begin
				if (in_valid) begin
					secs_q <= epoch_seconds[31:7];
					year_q <= ucal_pkg::YEAR_INIT;
					yc_q   <= ucal_pkg::YC_INIT;
					cc_q   <= ucal_pkg::CC_INIT;
					mon_q  <= '0;
				end
			end
			ucal_pkg::OP_DIV: begin
				days_q <= day_prod[ucal_pkg::RECIP_SHIFT +: ucal_pkg::QB];
			end
			ucal_pkg::OP_YEAR: begin
				if (!flags.year_done) begin
					days_q <= days_q - {{(ucal_pkg::QB-9){1'b0}}, ylen};
					year_q <= year_q + 1'b1;
					if (yc_q == ucal_pkg::YC_LAST) begin
						yc_q <= '0;
						cc_q <= cc_q + 1'b1;
					end else begin
						yc_q <= yc_q + 1'b1;
					end
				end
			end
			ucal_pkg::OP_MON: begin
				if (!flags.mon_done) begin
					days_q <= days_q - {{(ucal_pkg::QB-5){1'b0}}, mlen};
					mon_q  <= mon_q + 1'b1;
				end
			end
			ucal_pkg::OP_OUT: begin
				if (flags.out_free) begin
					year_out_q  <= year_q;
					month_out_q <= mon_q + 1'b1;
					day_out_q   <= days_q[4:0] + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == ucal_pkg::OP_OUT && flags.out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cal_year  = year_out_q;
	assign cal_month = month_out_q;
	assign cal_day   = day_out_q;

endmodule

FILE: hw/rtl/unix_seconds_to_calendar_date.sv
// Unix seconds to Gregorian date (year, month, day of month).
//
// Input channel: epoch_seconds with in_valid / in_stall. An item is taken
// when in_valid is high and in_stall is low. in_stall is low only while the
// sequencer sits in its wait step, so one item is converted at a time.
// Output channel: cal_year, cal_month, cal_day with out_valid / out_stall,
// held in an output register; a new item is accepted while a result waits.
//
// Each item runs a divide step (seconds to days by a multiply with the
// scaled reciprocal of 86400), then year steps, month steps and an output
// step. The year loop removes one year per cycle; the next item is taken
// only once the sequencer is back in its wait step.
// If the receiver stalls while a result is still held, the output step
// waits until the register frees up; held results never change.
// Reset returns the step counter to the wait step and clears out_valid.
module unix_seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] cal_year,
	output logic [3:0]  cal_month,
	output logic [4:0]  cal_day
);

	ucal_pkg::pc_t    pc_q;
	ucal_pkg::ucode_t word;
	ucal_pkg::ctl_t   ctl;
	ucal_pkg::flags_t flags;
	logic             go;

	ucal_rom u_rom (
		.addr (pc_q),
		.word (word)
	);

	assign ctl.op = word.op;

	always_comb begin
		case (word.op)
			ucal_pkg::OP_WAIT: go = flags.in_fire;
			ucal_pkg::OP_DIV:  go = 1'b1;
			ucal_pkg::OP_YEAR: go = flags.year_done;
			ucal_pkg::OP_MON:  go = flags.mon_done;
			ucal_pkg::OP_OUT:  go = flags.out_free;
			default:           go = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ucal_pkg::STEP_WAIT;
		end else if (go) begin
			pc_q <= word.nxt;
		end
	end

	ucal_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.flags         (flags),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cal_year      (cal_year),
		.cal_month     (cal_month),
		.cal_day       (cal_day)
	);

endmodule

FILE: hw/rtl/ucal_checker.sv
module ucal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] cal_year,
	input logic [3:0]  cal_month,
	input logic [4:0]  cal_day
);

	// one item in flight: input closes right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cal_year >= 12'd1970 && cal_year <= 12'd2106
			&& cal_month >= 4'd1 && cal_month <= 4'd12
			&& cal_day >= 5'd1 && cal_day <= 5'd31))
		else $error("date out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			($stable(cal_year) && $stable(cal_month) && $stable(cal_day)))
		else $error("stalled result changed");

endmodule

bind unix_seconds_to_calendar_date ucal_checker u_ucal_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned ITEMS_PER_PHASE = 188;
	localparam int unsigned CYCLE_LIMIT     = 800000;
	localparam int unsigned DRAIN_CYCLES    = 200;

	typedef struct {
		logic [ucal_pkg::YEAR_W-1:0] year;
		logic [3:0]                  month;
		logic [4:0]                  day;
	} date_t;

	class date_board;
		date_t dates_due[$];
		int    mismatches;

		function new();
			mismatches = 0;
		endfunction

		function bit is_leap(int unsigned yr);
			return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		endfunction

		function date_t civil_date(logic [31:0] secs);
			int unsigned days;
			int unsigned yr;
			int unsigned mo;
			int unsigned dlen;
			int unsigned ylen;
			bit          found;
			date_t       d;
			days = secs / ucal_pkg::SECS_PER_DAY;
			yr = 1970;
			ylen = is_leap(yr) ? 366 : 365;
			while (days >= ylen) begin
				days -= ylen;
				yr++;
				ylen = is_leap(yr) ? 366 : 365;
			end
			mo = 12;
			found = 0;
			for (int i = 0; i < 12; i++) begin
				if (!found) begin
					if (i == 1)
						dlen = is_leap(yr) ? 29 : 28;
					else if (i == 3 || i == 5 || i == 8 || i == 10)
						dlen = 30;
					else
						dlen = 31;
					if (days < dlen) begin
						mo = i + 1;
						found = 1;
					end else begin
						days -= dlen;
					end
				end
			end
			d.year  = yr[ucal_pkg::YEAR_W-1:0];
			d.month = mo[3:0];
			d.day   = 5'(days + 1);
			return d;
		endfunction

		function void note_seconds(logic [31:0] secs);
			dates_due.push_back(civil_date(secs));
		endfunction

		function void check_date(logic [ucal_pkg::YEAR_W-1:0] yr, logic [3:0] mo,
			logic [4:0] dy);
			date_t want;
			if (dates_due.size() == 0) begin
				$error("unexpected item: %0d-%0d-%0d", yr, mo, dy);
				mismatches++;
				return;
			end
			want = dates_due.pop_front();
			if (yr !== want.year) begin
				$error("cal_year: expected %0d, got %0d", want.year, yr);
				mismatches++;
			end
			if (mo !== want.month) begin
				$error("cal_month: expected %0d, got %0d", want.month, mo);
				mismatches++;
			end
			if (dy !== want.day) begin
				$error("cal_day: expected %0d, got %0d", want.day, dy);
				mismatches++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [31:0]                 epoch_seconds;
	logic                        out_valid;
	logic                        out_stall;
	logic [ucal_pkg::YEAR_W-1:0] cal_year;
	logic [3:0]                  cal_month;
	logic [4:0]                  cal_day;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	date_board   board;

	unix_seconds_to_calendar_date dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cal_year     (cal_year),
		.cal_month    (cal_month),
		.cal_day      (cal_day)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		epoch_seconds = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_seconds(epoch_seconds);
			if (out_valid && !out_stall)
				board.check_date(cal_year, cal_month, cal_day);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// Holds valid across back-to-back items; drops it only for an idle gap.
	task automatic send_seconds(logic [31:0] secs);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		epoch_seconds <= secs;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	function automatic logic [31:0] pick_seconds();
		longint unsigned wide;
		case ($urandom_range(4))
			0: return $urandom();
			1: begin
				// day edges: first or last second of a day
				wide = longint'($urandom_range(49710)) * ucal_pkg::SECS_PER_DAY;
				if ($urandom_range(1))
					wide += ucal_pkg::SECS_PER_DAY - 1;
				return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
			end
			2: return $urandom_range(32'd126230400);
			3: return $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
			default: begin
				wide = longint'($urandom_range(49710)) * ucal_pkg::SECS_PER_DAY
					+ $urandom_range(ucal_pkg::SECS_PER_DAY - 1);
				return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
			end
		endcase
	endfunction

	logic [31:0] directed_secs[$] = '{
		32'd0, 32'd86399, 32'd86400,
		32'd31535999, 32'd31536000,          // end of 1970 / start of 1971
		32'd68169600,                         // 1972-02-29
		32'd951782400, 32'd951868800,         // 2000-02-29, 2000-03-01
		32'd978220800, 32'd978307200,         // 2000-12-31, 2001-01-01
		32'd4107456000, 32'd4107542400,       // 2100 is not leap: 02-28, 03-01
		32'd4133894400, 32'd4133980800,       // 2100-12-31, 2101-01-01
		32'd4294943999, 32'd4294944000,       // end of the second-last day, start of the last day
		32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		32'hAAAA_AAAA, 32'h5555_5555
	};

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_secs[i])
			send_seconds(directed_secs[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 56; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 56; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			repeat (ITEMS_PER_PHASE)
				send_seconds(pick_seconds());
		end
		in_valid <= 1'b0;

		while (board.dates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.dates_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ucal_pkg.sv
hw/rtl/ucal_rom.sv
hw/rtl/ucal_datapath.sv
hw/rtl/unix_seconds_to_calendar_date.sv
hw/rtl/ucal_checker.sv
bench/tb_top.sv
